### rtl/tsop_pkg.sv
// ----------------------------------------------------------------------------
// tsop_pkg
// Shared types and codes for the TCP SYN option parser.
// ----------------------------------------------------------------------------
package tsop_pkg;

    // option kinds
    localparam logic [7:0] K_EOL   = 8'd0;
    localparam logic [7:0] K_NOP   = 8'd1;
    localparam logic [7:0] K_MSS   = 8'd2;
    localparam logic [7:0] K_WS    = 8'd3;
    localparam logic [7:0] K_SACKP = 8'd4;
    localparam logic [7:0] K_TS    = 8'd8;
    localparam logic [7:0] K_UTO   = 8'd28;
    localparam logic [7:0] K_AO    = 8'd29;

    // fixed option lengths
    localparam logic [7:0] LEN_MSS   = 8'd4;
    localparam logic [7:0] LEN_WS    = 8'd3;
    localparam logic [7:0] LEN_SACKP = 8'd2;
    localparam logic [7:0] LEN_TS    = 8'd10;
    localparam logic [7:0] LEN_UTO   = 8'd4;
    localparam logic [7:0] LEN_HDR   = 8'd2;

    // data bytes skipped after kind and length
    localparam logic [7:0] SKIP_TS  = 8'd8;
    localparam logic [7:0] SKIP_UTO = 8'd2;

    localparam logic [15:0] OWN_MSS_RESET = 16'd1460;

    typedef enum logic [1:0] {
        E_OK      = 2'd0,
        E_UNKNOWN = 2'd1,
        E_BADLEN  = 2'd2,
        E_TRUNC   = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        PH_KIND   = 3'd0,
        PH_LEN    = 3'd1,
        PH_SKIP   = 3'd2,
        PH_MSS_HI = 3'd3,
        PH_MSS_LO = 3'd4,
        PH_WS     = 3'd5,
        PH_DONE   = 3'd6
    } t_phase;

    // flag bits
    localparam int FLAG_SACK = 0;
    localparam int FLAG_TS   = 1;

    typedef struct packed {
        logic [15:0] mss;
        logic [7:0]  wnd_scale;
        logic        sack_ok;
        logic        tstamp_seen;
        t_err        error_code;
    } t_result;

endpackage

### rtl/tsop_parse.sv
// ----------------------------------------------------------------------------
// tsop_parse
// Per-byte option parser: holds the parse state and accumulators and
// builds the summary on the last byte of an option area.
// ----------------------------------------------------------------------------
module tsop_parse import tsop_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_result     o_result
);

    logic [15:0] r_own_mss, n_own_mss;
    t_phase      r_phase, n_phase;
    logic [7:0]  r_kind, n_kind;
    logic [7:0]  r_left, n_left;
    logic [15:0] r_mss_acc, n_mss_acc;
    logic [7:0]  r_scale, n_scale;
    logic [1:0]  r_flags, n_flags;
    t_err        r_err, n_err;

    t_phase      s_phase;
    logic [7:0]  s_left;
    logic [15:0] s_mss_acc;
    logic [7:0]  s_scale;
    logic [1:0]  s_flags;
    t_err        s_err;
    logic [7:0]  s_kind;
    logic [15:0] s_peer;
    logic [7:0]  s_left_dec;
    logic [7:0]  s_ao_left;

    assign s_peer     = {r_left, i_byte};
    assign s_left_dec = r_left - 8'd1;
    assign s_ao_left  = i_byte - LEN_HDR;

    // one parse step on the current byte
    always_comb begin
        s_phase   = r_phase;
        s_kind    = r_kind;
        s_left    = r_left;
        s_mss_acc = r_mss_acc;
        s_scale   = r_scale;
        s_flags   = r_flags;
        s_err     = r_err;
        unique case (r_phase)
            PH_KIND: begin
                case (i_byte) inside
                    K_EOL: s_phase = PH_DONE;
                    K_NOP: s_phase = PH_KIND;
                    K_MSS, K_WS, K_SACKP, K_TS, K_UTO, K_AO: begin
                        s_kind  = i_byte;
                        s_phase = PH_LEN;
                    end
                    default: begin
                        s_err   = E_UNKNOWN;
                        s_phase = PH_DONE;
                    end
                endcase
            end
            PH_LEN: begin
                case (r_kind)
                    K_MSS: begin
                        if (i_byte == LEN_MSS) s_phase = PH_MSS_HI;
                        else begin
                            s_err   = E_BADLEN;
                            s_phase = PH_DONE;
                        end
                    end
                    K_WS: begin
                        if (i_byte == LEN_WS) s_phase = PH_WS;
                        else begin
                            s_err   = E_BADLEN;
                            s_phase = PH_DONE;
                        end
                    end
                    K_SACKP: begin
                        if (i_byte == LEN_SACKP) begin
                            s_flags[FLAG_SACK] = 1'b1;
                            s_phase            = PH_KIND;
                        end else begin
                            s_err   = E_BADLEN;
                            s_phase = PH_DONE;
                        end
                    end
                    K_TS: begin
                        if (i_byte == LEN_TS) begin
                            s_left  = SKIP_TS;
                            s_phase = PH_SKIP;
                        end else begin
                            s_err   = E_BADLEN;
                            s_phase = PH_DONE;
                        end
                    end
                    K_UTO: begin
                        if (i_byte == LEN_UTO) begin
                            s_left  = SKIP_UTO;
                            s_phase = PH_SKIP;
                        end else begin
                            s_err   = E_BADLEN;
                            s_phase = PH_DONE;
                        end
                    end
                    default: begin
                        // authentication option, variable length
                        if (i_byte < LEN_HDR) begin
                            s_err   = E_BADLEN;
                            s_phase = PH_DONE;
                        end else begin
                            s_left  = s_ao_left;
                            s_phase = (s_ao_left == 8'd0) ? PH_KIND : PH_SKIP;
                        end
                    end
                endcase
            end
            PH_SKIP: begin
                s_left = s_left_dec;
                if (s_left_dec == 8'd0) begin
                    if (r_kind == K_TS) s_flags[FLAG_TS] = 1'b1;
                    s_phase = PH_KIND;
                end
            end
            PH_MSS_HI: begin
                s_left  = i_byte;
                s_phase = PH_MSS_LO;
            end
            PH_MSS_LO: begin
                if (s_peer < r_own_mss) s_mss_acc = s_peer;
                s_left  = 8'd0;
                s_phase = PH_KIND;
            end
            PH_WS: begin
                s_scale = i_byte;
                s_phase = PH_KIND;
            end
            default: begin
                // done or unused code: ignore the rest of the area
            end
        endcase
    end

    // summary for the last byte, with the truncation check
    always_comb begin
        o_result.mss         = s_mss_acc;
        o_result.wnd_scale   = s_scale;
        o_result.sack_ok     = s_flags[FLAG_SACK];
        o_result.tstamp_seen = s_flags[FLAG_TS];
        o_result.error_code  = s_err;
        if ((s_phase == PH_LEN || s_phase == PH_SKIP || s_phase == PH_MSS_HI ||
             s_phase == PH_MSS_LO || s_phase == PH_WS) && s_err == E_OK) begin
            o_result.error_code = E_TRUNC;
        end
    end

    // next state: config write, step, or rearm after the last byte
    always_comb begin
        n_own_mss = r_own_mss;
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_left    = r_left;
        n_mss_acc = r_mss_acc;
        n_scale   = r_scale;
        n_flags   = r_flags;
        n_err     = r_err;
        if (i_cfg_we) begin
            n_own_mss = i_cfg_data;
            n_mss_acc = i_cfg_data;
        end else if (i_step) begin
            if (i_last) begin
                n_phase   = PH_KIND;
                n_kind    = 8'd0;
                n_left    = 8'd0;
                n_mss_acc = r_own_mss;
                n_scale   = 8'd0;
                n_flags   = 2'd0;
                n_err     = E_OK;
            end else begin
                n_phase   = s_phase;
                n_kind    = s_kind;
                n_left    = s_left;
                n_mss_acc = s_mss_acc;
                n_scale   = s_scale;
                n_flags   = s_flags;
                n_err     = s_err;
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mss <= OWN_MSS_RESET;
            r_phase   <= PH_KIND;
            r_kind    <= 8'd0;
            r_left    <= 8'd0;
            r_mss_acc <= OWN_MSS_RESET;
            r_scale   <= 8'd0;
            r_flags   <= 2'd0;
            r_err     <= E_OK;
        end else begin
            r_own_mss <= n_own_mss;
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_left    <= n_left;
            r_mss_acc <= n_mss_acc;
            r_scale   <= n_scale;
            r_flags   <= n_flags;
            r_err     <= n_err;
        end
    end

    // a summary beat leaves the parser rearmed
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last && !i_cfg_we) |=>
            (r_phase == PH_KIND && r_flags == 2'd0 && r_err == E_OK &&
             r_mss_acc == r_own_mss))
        else $error("parser not rearmed after last byte");

    // a recorded error parks the parser in the done phase
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != E_OK) |-> (r_phase == PH_DONE))
        else $error("error recorded outside done phase");

    // the first error is kept until the area ends
    a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != E_OK && !(i_step && i_last)) |=> $stable(r_err))
        else $error("recorded error changed inside area");

    // negotiated mss never exceeds the local value
    a_mss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mss_acc <= r_own_mss))
        else $error("mss accumulator above own mss");

endmodule

### rtl/tsop_out.sv
// ----------------------------------------------------------------------------
// tsop_out
// Result register: holds one summary beat until the receiver takes it.
// ----------------------------------------------------------------------------
module tsop_out import tsop_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    // valid flag: set on load, cleared when taken
    always_comb begin
        n_valid = r_valid;
        if (i_load)            n_valid = 1'b1;
        else if (i_ready)      n_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    // never overwrite a beat the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_load && r_valid && !i_ready))
        else $error("result register overwritten while stalled");

    // a stalled beat stays in place
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_result)))
        else $error("stalled result changed");

endmodule

### rtl/tcp_syn_option_parser.sv
// ----------------------------------------------------------------------------
// tcp_syn_option_parser
// Byte-serial parser for the option area of a TCP SYN header.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries one option byte per beat,
//   with i_last high on the final byte of the area. Only the last byte
//   produces a result beat on the output channel (o_valid/i_ready):
//   negotiated mss, window scale, sack and timestamp flags, error code.
//   Config channel (i_cfg_valid/o_cfg_ready) writes own mss; ready while
//   no byte is held in the input register, and meant to be written only
//   while the parser is idle. A write also reloads the mss accumulator.
//   The last byte passes the input register, then the result register,
//   before o_valid rises. Throughput: one byte per cycle unless a last
//   byte meets a busy result register, set by the combinational parse
//   step between the input register and the result register.
//   Reset (synchronous, active low) rearms the parser and sets own mss
//   to 1460. When the receiver stalls, the result register holds its beat;
//   non-last bytes keep flowing, and a last byte waits in the input
//   register, with o_ready low, until the result register frees.
// ----------------------------------------------------------------------------
module tcp_syn_option_parser import tsop_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_own_mss,
    // option byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_opt_byte,
    input  logic        i_last,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_mss,
    output logic [7:0]  o_wnd_scale,
    output logic        o_sack_ok,
    output logic        o_tstamp_seen,
    output logic [1:0]  o_error_code
);

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic       s_out_free;
    logic       s_step;
    logic       s_cfg_we;
    t_result    s_result;
    t_result    s_out;

    // config write never meets a parse step of a held byte
    assign o_cfg_ready = !r_in_valid;
    assign s_cfg_we    = i_cfg_valid && o_cfg_ready;

    // a held byte moves on unless it is last and the result slot is busy
    assign s_step  = r_in_valid && (!r_in_last || s_out_free);
    assign o_ready = !r_in_valid || s_step;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_valid && o_ready) n_in_valid = 1'b1;
        else if (s_step)        n_in_valid = 1'b0;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_opt_byte;
            r_in_last <= i_last;
        end
    end

    tsop_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (s_cfg_we),
        .i_cfg_data (i_own_mss),
        .i_step     (s_step),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .o_result   (s_result)
    );

    tsop_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (s_step && r_in_last),
        .i_result (s_result),
        .o_free   (s_out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (s_out)
    );

    assign o_mss         = s_out.mss;
    assign o_wnd_scale   = s_out.wnd_scale;
    assign o_sack_ok     = s_out.sack_ok;
    assign o_tstamp_seen = s_out.tstamp_seen;
    assign o_error_code  = s_out.error_code;

    // a last byte only leaves the input register into a free result slot
    a_last_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && o_valid && !i_ready) |=> r_in_valid)
        else $error("last byte dropped while result stalled");

endmodule
